@@ hw/rtl/hpd_pkg.sv @@
// Shared types and constants for the hot pixel detector.
`default_nettype none

package hpd_pkg;

    localparam int SAMP_W    = 16;  // width of one input sample field
    localparam int FW_W      = 13;  // frame_width register
    localparam int ROW_W     = 16;  // row counter and frame_height register
    localparam int PCOL_W    = 12;  // reported column
    localparam int THR_W     = 8;   // threshold_eighths register
    localparam int CFG_W     = 16;  // configuration write data
    localparam int CFG_IDX_W = 2;   // configuration register index

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_THREE_CHANNEL = 2'd2,
        CFG_THRESHOLD     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMP_W-1:0] sample_a;
        logic [SAMP_W-1:0] sample_b;
        logic [SAMP_W-1:0] sample_c;
        logic              frame_start;
    } t_hpd_in;

    typedef struct packed {
        logic              is_hot;
        logic [PCOL_W-1:0] pixel_col;
        logic [ROW_W-1:0]  pixel_row;
        logic              judged;
        logic              frame_done;
    } t_hpd_out;

    // Per-word bookkeeping that travels down the pipeline beside the data.
    typedef struct packed {
        logic              judged;
        logic              frame_done;
        logic [PCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
    } t_hpd_tag;

endpackage

`default_nettype wire

@@ hw/rtl/hpd_stream_if.sv @@
// Valid/ready stream interface carrying one word of a given payload type.
`default_nettype none

interface hpd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hpd_line_store.sv @@
// Four banks of line memory holding the previous four rows, one bank per row modulo four.
`default_nettype none

module hpd_line_store import hpd_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    parameter int SW        = 16,
    parameter int CW        = 12
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [CW-1:0]            i_addr,
    input  logic [1:0]               i_bank,
    input  logic [3*SW-1:0]          i_wdata,
    output logic [3:0][3*SW-1:0]     o_col
);

    logic [3*SW-1:0] rd_data [4];
    logic [1:0]      r_rot;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [3*SW-1:0] r_bank [MAX_WIDTH];
        logic [3*SW-1:0] r_rd;

        // Read returns the old contents when the same entry is written.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rd <= r_bank[i_addr];
            end
            if (i_we && (i_bank == 2'(b))) begin
                r_bank[i_addr] <= i_wdata;
            end
        end

        assign rd_data[b] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= i_bank;
        end
    end

    // Output k is the row k lines below the oldest: bank (row + k) mod 4.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_col[k] = rd_data[2'(r_rot + 2'(k))];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hpd_lane.sv @@
// One judging lane: sums eight neighbors, then compares eight times the center with the scaled sum.
`default_nettype none

module hpd_lane import hpd_pkg::*; #(
    parameter int SW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SW-1:0]        i_centre,
    input  logic [7:0][SW-1:0]   i_nb,
    input  logic [THR_W-1:0]     i_thr,
    output logic                 o_hot
);

    localparam int PW = SW + 3 + THR_W;

    logic [SW:0]   pair [4];
    logic [SW+1:0] quad [2];
    logic [SW+2:0] sum;
    logic [SW+2:0] r_sum;
    logic [SW-1:0] r_centre;
    logic [PW-1:0] prod;
    logic [PW-1:0] lhs;
    logic          r_hot;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pair[k] = {1'b0, i_nb[2*k]} + {1'b0, i_nb[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            quad[k] = {1'b0, pair[2*k]} + {1'b0, pair[2*k+1]};
        end
        sum = {1'b0, quad[0]} + {1'b0, quad[1]};
    end

    assign prod = PW'(r_sum) * PW'(i_thr);
    assign lhs  = PW'({r_centre, 3'b000});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum    <= sum;
            r_centre <= i_centre;
            r_hot    <= (lhs > prod);
        end
    end

    assign o_hot = r_hot;

endmodule

`default_nettype wire

@@ hw/rtl/hpd_merge.sv @@
// Combines the lane verdicts for the selected mode and holds the result word for the sink.
`default_nettype none

module hpd_merge import hpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_hpd_tag  i_tag,
    input  logic [2:0] i_hot,
    input  logic      i_three_ch,
    output logic      o_valid,
    output t_hpd_out  o_res
);

    logic     r_valid;
    t_hpd_out r_res;
    logic     hot_any;

    // Mosaic mode uses lane 0 alone; three-channel mode flags any channel.
    assign hot_any = i_three_ch ? (|i_hot) : i_hot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.is_hot     <= i_tag.judged && hot_any;
            r_res.pixel_col  <= i_tag.col;
            r_res.pixel_row  <= i_tag.row;
            r_res.judged     <= i_tag.judged;
            r_res.frame_done <= i_tag.frame_done;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/hot_pixel_detector.sv @@
// Top level of the hot pixel detector: counters, window, lanes and result merge.
`default_nettype none

// The block takes a dark frame in raster order, one pixel word per clock, and returns one
// result word for every pixel word. Once the window around a pixel is complete, the pixel is
// judged: in mosaic mode its sample is compared with the eight same-color samples two steps
// away, and in three-channel mode each channel is compared with its eight 3x3 neighbors. A
// pixel is hot when eight times the center exceeds threshold_eighths times the neighbor sum.
// Throughput is one word per clock while the output is not stalled. The line store read, in
// which all four banks are read and only the bank of the oldest line is written, happens at
// the accepting edge; the window shift, two lane stages and the output register follow in
// that order. The whole pipeline advances together whenever the output register is empty or
// being drained, so input is refused only while a finished result waits at the output. The
// line store powers up with unknown contents and needs no clearing: every pixel that is
// judged reads only lines written earlier in the same frame. Configuration must be written
// only while the block is idle.
module hot_pixel_detector import hpd_pkg::*; #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hpd_stream_if.sink           i_pix,
    hpd_stream_if.source         o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SW = (SAMPLE_BITS < SAMP_W) ? SAMPLE_BITS : SAMP_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    // Configuration registers.
    logic [FW_W-1:0]  r_frame_width;
    logic [ROW_W-1:0] r_frame_height;
    logic             r_three_ch;
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(4096);
            r_frame_height <= ROW_W'(4096);
            r_three_ch     <= 1'b0;
            r_thr          <= THR_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data[ROW_W-1:0];
                CFG_THREE_CHANNEL: r_three_ch     <= i_cfg_data[0];
                CFG_THRESHOLD:     r_thr          <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake. The pipeline moves as one whenever the output register can take a word.
    logic adv;
    logic acc;
    logic out_valid;

    assign adv         = !out_valid || o_res.ready;
    assign i_pix.ready = adv;
    assign acc         = i_pix.valid && adv;

    // Position counters. A frame start places the word at the origin.
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [XW-1:0]    col_p1;
    logic [ROW_W:0]   row_p1;
    logic             end_row;
    logic             end_frame;

    assign cur_col = i_pix.payload.frame_start ? '0 : r_col;
    assign cur_row = i_pix.payload.frame_start ? '0 : r_row;
    assign col_p1  = XW'(cur_col) + XW'(1);
    assign row_p1  = {1'b0, cur_row} + (ROW_W+1)'(1);

    // A zero width or height behaves as one, and the row never runs past the line store.
    assign end_row   = (col_p1 >= XW'(r_frame_width)) || (cur_col == CW'(MAX_WIDTH - 1));
    assign end_frame = end_row && (row_p1 >= {1'b0, r_frame_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= end_frame ? '0 : row_p1[ROW_W-1:0];
            end else begin
                r_col <= col_p1[CW-1:0];
                r_row <= cur_row;
            end
        end
    end

    // Decide at acceptance whether this word completes a window, and which pixel it judges.
    // Mosaic windows are 5x5 and center two back; three-channel windows are 3x3 and center one back.
    logic             jdg;
    logic [CW-1:0]    jcol;
    logic [ROW_W-1:0] jrow;
    t_hpd_tag         n_tag;

    always_comb begin
        if (r_three_ch) begin
            jdg  = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
            jcol = cur_col - CW'(1);
            jrow = cur_row - ROW_W'(1);
        end else begin
            jdg  = (cur_row >= ROW_W'(4)) && (cur_col >= CW'(4));
            jcol = cur_col - CW'(2);
            jrow = cur_row - ROW_W'(2);
        end
        n_tag.judged     = jdg;
        n_tag.frame_done = end_frame;
        n_tag.col        = jdg ? PCOL_W'(jcol) : '0;
        n_tag.row        = jdg ? jrow : '0;
    end

    // Current pixel, cut to the sample width.
    logic [3*SW-1:0] cur_pix;

    assign cur_pix = {i_pix.payload.sample_c[SW-1:0],
                      i_pix.payload.sample_b[SW-1:0],
                      i_pix.payload.sample_a[SW-1:0]};

    // Line store: reads the column above the new word while the word replaces the oldest line.
    logic [3:0][3*SW-1:0] ls_col;

    hpd_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .SW        (SW),
        .CW        (CW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (acc),
        .i_addr  (cur_col),
        .i_bank  (cur_row[1:0]),
        .i_wdata (cur_pix),
        .o_col   (ls_col)
    );

    // Pipeline bookkeeping: stage 1 after acceptance, 2 after the window shift,
    // 3 and 4 inside the lanes.
    logic [4:1]      r_vld;
    t_hpd_tag        r_tag [1:4];
    logic [3*SW-1:0] r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[3:1], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[1] <= n_tag;
            r_tag[2] <= r_tag[1];
            r_tag[3] <= r_tag[2];
            r_tag[4] <= r_tag[3];
            r_cur    <= cur_pix;
        end
    end

    // The 5x5 window shifts left by one column for each pixel word; row 4 is the newest line.
    logic [3*SW-1:0] r_win [5][5];

    always_ff @(posedge i_clk) begin
        if (adv && r_vld[1]) begin
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            for (int i = 0; i < 4; i++) begin
                r_win[i][4] <= ls_col[i];
            end
            r_win[4][4] <= r_cur;
        end
    end

    // Tap selection for the three lanes. In mosaic mode only lane 0 counts.
    logic [SW-1:0]      lane_centre [3];
    logic [7:0][SW-1:0] lane_nb     [3];
    logic [2:0]         lane_hot;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_three_ch) begin
                lane_centre[c] = r_win[3][3][c*SW +: SW];
                lane_nb[c][0]  = r_win[2][2][c*SW +: SW];
                lane_nb[c][1]  = r_win[2][3][c*SW +: SW];
                lane_nb[c][2]  = r_win[2][4][c*SW +: SW];
                lane_nb[c][3]  = r_win[3][2][c*SW +: SW];
                lane_nb[c][4]  = r_win[3][4][c*SW +: SW];
                lane_nb[c][5]  = r_win[4][2][c*SW +: SW];
                lane_nb[c][6]  = r_win[4][3][c*SW +: SW];
                lane_nb[c][7]  = r_win[4][4][c*SW +: SW];
            end else begin
                lane_centre[c] = r_win[2][2][SW-1:0];
                lane_nb[c][0]  = r_win[0][0][SW-1:0];
                lane_nb[c][1]  = r_win[0][2][SW-1:0];
                lane_nb[c][2]  = r_win[0][4][SW-1:0];
                lane_nb[c][3]  = r_win[2][0][SW-1:0];
                lane_nb[c][4]  = r_win[2][4][SW-1:0];
                lane_nb[c][5]  = r_win[4][0][SW-1:0];
                lane_nb[c][6]  = r_win[4][2][SW-1:0];
                lane_nb[c][7]  = r_win[4][4][SW-1:0];
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        hpd_lane #(
            .SW (SW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_centre (lane_centre[c]),
            .i_nb     (lane_nb[c]),
            .i_thr    (r_thr),
            .o_hot    (lane_hot[c])
        );
    end

    // Merge the lane verdicts into the result word.
    t_hpd_out res_word;

    hpd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (r_vld[4]),
        .i_tag      (r_tag[4]),
        .i_hot      (lane_hot),
        .i_three_ch (r_three_ch),
        .o_valid    (out_valid),
        .o_res      (res_word)
    );

    assign o_res.valid   = out_valid;
    assign o_res.payload = res_word;

    // A result waiting at the output must hold off new input.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_pix.ready)
        else $error("input accepted while output is stalled");

    // The column counter never leaves the line store's address range.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH - 1))
        else $error("column counter out of range");

    // A result that judged nothing carries no verdict and no position.
    a_unjudged_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.payload.judged) |->
        (!o_res.payload.is_hot && (o_res.payload.pixel_col == '0) &&
         (o_res.payload.pixel_row == '0)))
        else $error("unjudged result carries data");

    // A frame start on a row that continues leaves the counter on the second column.
    a_frame_start_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_pix.payload.frame_start && !end_row) |=> (r_col == CW'(1)))
        else $error("frame start did not restart the column count");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the hot pixel detector: stimulus, prediction and checking.
`timescale 1ns / 100ps

import hpd_pkg::*;

// Tracks the detector's state from the pixel words it accepts and holds the verdicts it owes.
class hot_pixel_tracker;
    localparam int LINE_LEN = 4096;

    typedef bit [2:0][SAMP_W-1:0] t_rgb;

    t_rgb        line_buf [4*LINE_LEN];
    t_rgb        win [5][5];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_reg;
    int unsigned height_reg;
    bit          rgb_mode;
    int unsigned thr_eighths;
    t_hpd_out    pending[$];
    int          failures;

    function new();
        col_pos     = 0;
        row_pos     = 0;
        width_reg   = 4096;
        height_reg  = 4096;
        rgb_mode    = 1'b0;
        thr_eighths = 10;
        failures    = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, bit [CFG_W-1:0] d);
        case (idx)
            CFG_FRAME_WIDTH:   width_reg   = d[FW_W-1:0];
            CFG_FRAME_HEIGHT:  height_reg  = d[ROW_W-1:0];
            CFG_THREE_CHANNEL: rgb_mode    = d[0];
            CFG_THRESHOLD:     thr_eighths = d[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_LEN) return LINE_LEN;
        return width_reg;
    endfunction

    function bit channel_hot(int unsigned centre, longint unsigned sum);
        return (longint'(centre) * 8) > (sum * thr_eighths);
    endfunction

    // Advances the window by one pixel and queues the verdict this pixel produces.
    function void record_pixel(t_hpd_in w);
        t_rgb            cur;
        t_hpd_out        v;
        int unsigned     wd;
        int unsigned     ht;
        int unsigned     c;
        int unsigned     r;
        longint unsigned sum;
        bit              hot;
        bit              end_row;
        bit              end_frame;
        wd = eff_width();
        ht = (height_reg == 0) ? 1 : height_reg;
        if (w.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c >= LINE_LEN) c = LINE_LEN - 1;
        cur = {w.sample_c, w.sample_b, w.sample_a};

        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                win[i][j] = win[i][j+1];
        for (int i = 0; i < 4; i++)
            win[i][4] = line_buf[((r + i) & 3) * LINE_LEN + c];
        win[4][4] = cur;
        line_buf[(r & 3) * LINE_LEN + c] = cur;

        v   = '0;
        hot = 1'b0;
        if (!rgb_mode) begin
            if (r >= 4 && c >= 4) begin
                sum = 0;
                for (int i = 0; i < 5; i += 2)
                    for (int j = 0; j < 5; j += 2)
                        if (!(i == 2 && j == 2)) sum += win[i][j][0];
                v.is_hot    = channel_hot(win[2][2][0], sum);
                v.judged    = 1'b1;
                v.pixel_col = PCOL_W'(c - 2);
                v.pixel_row = ROW_W'(r - 2);
            end
        end else if (r >= 2 && c >= 2) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum = 0;
                for (int i = 2; i < 5; i++)
                    for (int j = 2; j < 5; j++)
                        if (!(i == 3 && j == 3)) sum += win[i][j][ch];
                if (channel_hot(win[3][3][ch], sum)) hot = 1'b1;
            end
            v.is_hot    = hot;
            v.judged    = 1'b1;
            v.pixel_col = PCOL_W'(c - 1);
            v.pixel_row = ROW_W'(r - 1);
        end

        end_row   = (c + 1 >= wd);
        end_frame = end_row && (r + 1 >= ht);
        if (end_row) begin
            col_pos = 0;
            row_pos = end_frame ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        v.frame_done = end_frame;
        pending = {pending, v};
    endfunction

    function void compare_verdict(t_hpd_out got);
        t_hpd_out want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result word: hot=%0d col=%0d row=%0d judged=%0d done=%0d",
                         got.is_hot, got.pixel_col, got.pixel_row, got.judged, got.frame_done);
            return;
        end
        want = pending.pop_front();
        if (got.is_hot !== want.is_hot || got.pixel_col !== want.pixel_col ||
            got.pixel_row !== want.pixel_row || got.judged !== want.judged ||
            got.frame_done !== want.frame_done) begin
            failures++;
            if (failures <= 10)
                $display("verdict mismatch: expected hot=%0d col=%0d row=%0d judged=%0d done=%0d,",
                         want.is_hot, want.pixel_col, want.pixel_row, want.judged,
                         want.frame_done,
                         " got hot=%0d col=%0d row=%0d judged=%0d done=%0d",
                         got.is_hot, got.pixel_col, got.pixel_row,
                         got.judged, got.frame_done);
        end
    endfunction

    function void close_out();
        if (pending.size() != 0) begin
            failures += pending.size();
            $display("%0d verdicts never arrived", pending.size());
        end
    endfunction
endclass

module testbench;
    // Cycles without any word taken on either channel before the run is declared hung. This is a
    // wide margin over the idle stretches of a correct run.
    localparam int QUIET_LIMIT  = 4000;
    // Rough number of pixel words for the whole run. The randomized small-frame phases stop
    // short of it to leave room for the wide row at the end.
    localparam int RANDOM_ITEMS = 1550;
    // Pixel words sent on the wide row at the end.
    localparam int WIDE_ITEMS   = 200;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    hpd_stream_if #(.T(t_hpd_in))  pix_if ();
    hpd_stream_if #(.T(t_hpd_out)) res_if ();

    hot_pixel_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    hot_pixel_tracker tracker = new();

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every word taken on either channel goes to the tracker at the edge that takes it. A pixel is
    // registered in the pipeline before its verdict appears, so the two never share an edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) tracker.record_pixel(pix_if.payload);
        if (i_rst_n && res_if.valid && res_if.ready) tracker.compare_verdict(res_if.payload);
    end

    // The result side switches between stall patterns: always ready, light, medium and heavy random
    // stalls, and a fixed duty cycle. Each pattern holds for a random number of cycles.
    int stall_mode;
    int stall_left = 0;
    int stall_tick = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 3) != 0);
            2: res_if.ready <= 1'($urandom_range(0, 1));
            3: res_if.ready <= ($urandom_range(0, 4) == 0);
            default: res_if.ready <= ((stall_tick % 7) < 4);
        endcase
    end

    // Watchdog: a run that stops moving words is a failure.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[hot_pixel_detector] ERROR");
            $finish;
        end
    end

    // Holds one pixel word on the input until the block takes it, then returns at the next
    // falling edge with valid still high so that a following word can go out without a bubble.
    task automatic send_pixel(input t_hpd_in w);
        pix_if.valid   <= 1'b1;
        pix_if.payload <= w;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Registers may only change with the pipeline empty. Every word gives a verdict, so once
    // none is owed the block holds no work.
    task automatic wait_drained();
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // One register write per cycle; the enable stays high between back-to-back writes.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        tracker.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    // Writes all four registers. When the effective width grows, the next frame has to start
    // from the top, or the upper lines of the window would hold columns never stored.
    bit restart_frame;

    task automatic apply_setup(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] ht,
                               input bit rgb, input logic [CFG_W-1:0] thr);
        int unsigned old_w;
        wait_drained();
        old_w = tracker.eff_width();
        write_reg(CFG_FRAME_WIDTH, wd);
        write_reg(CFG_FRAME_HEIGHT, ht);
        write_reg(CFG_THREE_CHANNEL, CFG_W'(rgb));
        write_reg(CFG_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
        restart_frame = (tracker.eff_width() > old_w) &&
                        (tracker.col_pos != 0 || tracker.row_pos != 0);
    endtask

    function automatic logic [SAMP_W-1:0] clip(input int unsigned v);
        return (v > 65535) ? 16'hFFFF : SAMP_W'(v);
    endfunction

    // A dark frame is a flat, slightly noisy background. Most pixels follow it; some carry a
    // spike on one channel, and a few are pure noise, black or saturated. A rare stray
    // frame_start breaks the raster in the middle of a frame.
    function automatic t_hpd_in make_pixel(input int unsigned base);
        t_hpd_in w;
        int      pick;
        pick          = $urandom_range(0, 99);
        w.sample_a    = clip(base + $urandom_range(0, base / 4 + 1));
        w.sample_b    = clip(base + $urandom_range(0, base / 4 + 1));
        w.sample_c    = clip(base + $urandom_range(0, base / 4 + 1));
        w.frame_start = ($urandom_range(0, 299) == 0);
        if (pick < 8) begin
            w.sample_a = SAMP_W'($urandom);
            w.sample_b = SAMP_W'($urandom);
            w.sample_c = SAMP_W'($urandom);
        end else if (pick < 10) begin
            w.sample_a = '0;
            w.sample_b = '0;
            w.sample_c = '0;
        end else if (pick < 12) begin
            w.sample_a = '1;
            w.sample_b = '1;
            w.sample_c = '1;
        end else if (pick < 18) begin
            case ($urandom_range(0, 2))
                0: w.sample_a = clip(base * $urandom_range(3, 40) + $urandom_range(1, 64));
                1: w.sample_b = clip(base * $urandom_range(3, 40) + $urandom_range(1, 64));
                default: w.sample_c = clip(base * $urandom_range(3, 40) + $urandom_range(1, 64));
            endcase
        end
        return w;
    endfunction

    // Streams n pixel words in bursts of random length, now and then a long one, with random gaps
    // between bursts that are sometimes zero.
    task automatic run_items(input int n, input int unsigned base, input bit first_start);
        int      burst_left;
        int      gap;
        t_hpd_in w;
        burst_left = 0;
        for (int k = 0; k < n; k++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 25);
                if (gap > 0) begin
                    pix_if.valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            w = make_pixel(base);
            if (k == 0) w.frame_start = first_start;
            send_pixel(w);
            burst_left--;
        end
        pix_if.valid <= 1'b0;
    endtask

    function automatic t_hpd_in make_word(input logic [SAMP_W-1:0] a, input logic [SAMP_W-1:0] b,
                                          input logic [SAMP_W-1:0] c, input logic fs);
        t_hpd_in w;
        w.sample_a    = a;
        w.sample_b    = b;
        w.sample_c    = c;
        w.frame_start = fs;
        return w;
    endfunction

    function automatic int unsigned pick_width();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(3, 14);
        if (sel < 85) return $urandom_range(15, 40);
        return $urandom_range(0, 4);
    endfunction

    initial begin
        int          sent;
        int          n;
        int unsigned wd;
        int unsigned ht;
        int unsigned thr;
        int unsigned base;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_FRAME_WIDTH;
        i_cfg_data     <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.payload <= '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Settings as they come out of reset: black and saturated words, nothing judged yet.
        send_pixel(make_word('0, '0, '0, 1'b1));
        send_pixel(make_word('1, '1, '1, 1'b0));
        pix_if.valid <= 1'b0;

        // Smallest three-channel frame, one judged pixel per frame, threshold zero. In the
        // first frame only the third channel of the center is lit, so that channel alone makes
        // it hot. The second frame follows by wrap-around, without frame_start: a black center
        // inside saturated neighbors is never hot.
        apply_setup(16'd3, 16'd3, 1'b1, 16'd0);
        for (int k = 0; k < 9; k++)
            send_pixel(make_word('0, '0, (k == 4) ? 16'd1 : 16'd0, k == 0));
        for (int k = 0; k < 9; k++)
            send_pixel(make_word('0, (k == 4) ? 16'd0 : 16'hFFFF, '0, 1'b0));
        pix_if.valid <= 1'b0;

        // Zero width and height act as one: every word ends its own frame.
        apply_setup(16'd0, 16'd0, 1'b0, 16'd255);
        send_pixel(make_word(16'hFFFF, '0, 16'hFFFF, 1'b1));
        send_pixel(make_word('0, 16'hFFFF, '0, 1'b0));
        send_pixel(make_word(16'h5A5A, 16'hA5A5, 16'h0F0F, 1'b0));
        pix_if.valid <= 1'b0;

        // Smallest mosaic frame, repeated by wrap-around at the default ratio.
        apply_setup(16'd5, 16'd5, 1'b0, 16'd10);
        run_items(150, $urandom_range(0, 3000), 1'b1);
        sent = 150;

        // A tall frame that never ends here, first at threshold zero, then narrowed in the
        // middle of a row at the top threshold: the row in progress ends at once.
        apply_setup(16'd16, 16'hFFFF, 1'b0, 16'd0);
        run_items(120, $urandom_range(0, 3000), 1'b1);
        apply_setup(16'd9, 16'hFFFF, 1'b0, 16'd255);
        run_items(100, $urandom_range(0, 3000), restart_frame);
        sent += 220;

        // Random small frames in both modes, with thresholds around the useful range and at
        // the extremes. Some setups continue the frame in progress.
        while (sent < RANDOM_ITEMS - WIDE_ITEMS) begin
            wd = pick_width();
            ht = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 65535)
                                              : $urandom_range(1, 10);
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = $urandom_range(0, 255);
                default: thr = $urandom_range(6, 14);
            endcase
            base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3000);
            n    = $urandom_range(60, 200);
            apply_setup(CFG_W'(wd), CFG_W'(ht), 1'($urandom_range(0, 1)), CFG_W'(thr));
            run_items(n, base, restart_frame || ($urandom_range(0, 3) != 0));
            sent += n;
        end

        // A width beyond the line store, written with every data bit set, is held to the
        // store's length. With a height of zero each full row is a frame of its own; this
        // walks the start of such a row.
        apply_setup(16'hFFFF, 16'd0, 1'b1, 16'd10);
        run_items(WIDE_ITEMS, $urandom_range(0, 3000), 1'b1);

        wait_drained();
        repeat (12) @(posedge i_clk);
        tracker.close_out();
        if (tracker.failures == 0)
            $display("[hot_pixel_detector] OK");
        else
            $display("[hot_pixel_detector] ERROR");
        $finish;
    end
endmodule

@@ hot_pixel_detector.f @@
hw/rtl/hpd_pkg.sv
hw/rtl/hpd_stream_if.sv
hw/rtl/hpd_line_store.sv
hw/rtl/hpd_lane.sv
hw/rtl/hpd_merge.sv
hw/rtl/hot_pixel_detector.sv
bench/testbench.sv
